// ----- rtl/core/hnta_pkg.sv -----
// hnta_pkg: shared constants, default calibration table and operation codes
// for the hall sensor angle estimator; used by every module in rtl/core except hnta_lane
`default_nettype none
package hnta_pkg;

    localparam int NUM_ENTRIES_DEF     = 12;
    localparam int SAMPLE_BITS_DEF     = 12;
    localparam int ANGLE_FRAC_BITS_DEF = 10;

    localparam int FIELD_BITS   = 12;
    localparam int DEFAULT_BITS = 16;
    localparam int DEFAULT_ROWS = 12;
    localparam int ROOT_SHIFT   = 28;
    localparam int SCALE_BITS   = 40;
    localparam int INDEX_BITS   = 4;
    localparam int ANGLE_BITS   = 15;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef logic [DEFAULT_BITS-1:0] t_default_row [3];

    localparam logic [DEFAULT_BITS-1:0] DEFAULT_TRIPLES [DEFAULT_ROWS][3] = '{
        '{16'd2626, 16'd2902, 16'd2995}, '{16'd2402, 16'd2767, 16'd3024},
        '{16'd2331, 16'd2590, 16'd3006}, '{16'd2290, 16'd2375, 16'd2795},
        '{16'd2263, 16'd2224, 16'd2549}, '{16'd2418, 16'd2259, 16'd2426},
        '{16'd2628, 16'd2328, 16'd2364}, '{16'd2861, 16'd2447, 16'd2331},
        '{16'd2942, 16'd2601, 16'd2331}, '{16'd2989, 16'd2835, 16'd2532},
        '{16'd3008, 16'd2997, 16'd2766}, '{16'd2851, 16'd2977, 16'd2915}
    };

endpackage
`default_nettype wire

// ----- rtl/core/hnta_lane.sv -----
// hnta_lane: squared euclidean distance of one calibration entry to the
// reference triple, registered; depends on nothing
`default_nettype none
module hnta_lane #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic [2:0][SAMPLE_BITS-1:0] i_entry,
    input  wire logic [2:0][SAMPLE_BITS-1:0] i_ref,
    output logic [2*SAMPLE_BITS+1:0]        o_d2
);
    localparam int D2_W = 2*SAMPLE_BITS+2;

    logic [2:0][SAMPLE_BITS-1:0]   w_diff;
    logic [2:0][2*SAMPLE_BITS-1:0] w_sq;
    logic [D2_W-1:0]               n_d2;
    logic [D2_W-1:0]               r_d2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = (i_entry[k] >= i_ref[k]) ? i_entry[k] - i_ref[k]
                                                : i_ref[k] - i_entry[k];
            w_sq[k]   = w_diff[k] * w_diff[k];
        end
        n_d2 = D2_W'(w_sq[0]) + D2_W'(w_sq[1]) + D2_W'(w_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        r_d2 <= n_d2;
    end

    assign o_d2 = r_d2;

endmodule
`default_nettype wire

// ----- rtl/core/hnta_sqrt.sv -----
// hnta_sqrt: bit-serial integer square root of d2 * 2^28, one root bit
// per cycle; uses hnta_pkg
`default_nettype none
module hnta_sqrt #(
    parameter int IN_W = 26
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [IN_W-1:0]                        i_d2,
    output logic                                        o_done,
    output logic [(IN_W+hnta_pkg::ROOT_SHIFT)/2-1:0]    o_root
);
    localparam int RAD_W  = IN_W + hnta_pkg::ROOT_SHIFT;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  w_rem2;
    logic [REM_W+1:0]  w_trial;

    assign w_rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rad  <= {i_d2, {hnta_pkg::ROOT_SHIFT{1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_rad <= r_rad << 2;
                if (w_rem2 >= w_trial) begin
                    r_rem  <= REM_W'(w_rem2 - w_trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(w_rem2);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ----- rtl/core/hnta_div.sv -----
// hnta_div: restoring divider for the rounded correction
// (mag * 2^frac + den/2) / den, one quotient bit per cycle; uses hnta_pkg
`default_nettype none
module hnta_div #(
    parameter int FRAC = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [hnta_pkg::SCALE_BITS-1:0]  i_mag,
    input  wire logic [hnta_pkg::SCALE_BITS-1:0]  i_den,
    output logic                                  o_done,
    output logic [FRAC:0]                         o_quot
);
    localparam int DW    = hnta_pkg::SCALE_BITS;
    localparam int NUM_W = DW + FRAC + 1;
    localparam int CNT_W = $clog2(FRAC + 2);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsr;
    logic [FRAC:0]    r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_ge;

    assign w_ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= (NUM_W'(i_mag) << FRAC) + NUM_W'(i_den >> 1);
                r_dsr  <= NUM_W'(i_den) << FRAC;
                r_quot <= '0;
                r_cnt  <= CNT_W'(FRAC + 1);
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsr;
                end
                r_quot <= {r_quot[FRAC-1:0], w_ge};
                r_dsr  <= r_dsr >> 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ----- rtl/core/hall_nearest_table_angle.sv -----
// hall_nearest_table_angle: hall sensor angle estimator top level with the
// calibration table, distance lanes, nearest-entry merge and sequencer;
// uses hnta_pkg, hnta_lane, hnta_sqrt, hnta_div
//
// A write beat (tuser = 0) stores one calibration triple when its index is
// below NUM_ENTRIES and gives no output beat. A convert beat (tuser = 1)
// holds off the input from its accept until its result is loaded into the
// output register; scaling the products can add steps, the divider is
// skipped when the correction is zero, and the load waits while the output
// register is still held by m_tready.
// All entries are measured at once by one lane per entry, the lanes are
// merged one per cycle to find the nearest entry, and the four roots go one
// after another through a single bit-serial root unit followed by a
// bit-serial divider. One convert is in work at a time; the finished result
// sits in the output register so the next beat is taken while it waits.
// The table resets to the built-in twelve triples.
`default_nettype none
module hall_nearest_table_angle #(
    parameter int NUM_ENTRIES     = hnta_pkg::NUM_ENTRIES_DEF,
    parameter int SAMPLE_BITS     = hnta_pkg::SAMPLE_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = hnta_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[3:0], sample_a[15:4], sample_b[27:16], sample_c[39:28]
    input  wire logic [39:0] s_tdata,
    // operation[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // angle[14:0], nearest_entry[18:15], zero[23:19]
    output logic [23:0]      m_tdata
);
    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int D2_W   = 2*SAMPLE_BITS + 2;
    localparam int ROOT_W = (D2_W + hnta_pkg::ROOT_SHIFT) / 2;
    localparam int PROD_W = 2*ROOT_W;
    localparam int SB     = hnta_pkg::SCALE_BITS;
    localparam int ANG_W  = $clog2(2*NUM_ENTRIES + 1) + ANGLE_FRAC_BITS + 2;
    localparam logic signed [ANG_W-1:0] TURN =
        ANG_W'(2*NUM_ENTRIES) <<< ANGLE_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_SCAN, S_GET, S_ROOT, S_RWAIT, S_MULN, S_MULL,
        S_NORM, S_DIV, S_DWAIT, S_ANG, S_OUT
    } t_state;

    typedef logic [2:0][SAMPLE_BITS-1:0] t_triple;

    function automatic logic [SAMPLE_BITS-1:0] to_smp(
        input logic [hnta_pkg::FIELD_BITS-1:0] v
    );
        logic [hnta_pkg::DEFAULT_BITS-1:0] ext;
        ext = hnta_pkg::DEFAULT_BITS'(v);
        return ext[SAMPLE_BITS-1:0];
    endfunction

    t_state                r_state;
    t_triple               r_tab [NUM_ENTRIES];
    t_triple               r_ref;
    logic [D2_W-1:0]       w_lane [NUM_ENTRIES];
    logic [IDX_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_phase;
    logic [D2_W-1:0]       r_best;
    logic [1:0]            r_k;
    logic [D2_W-1:0]       r_d2 [4];
    logic [ROOT_W-1:0]     r_rt [4];
    logic [PROD_W-1:0]     r_nn;
    logic [PROD_W-1:0]     r_ll;
    logic                  r_zero;
    logic                  r_neg;
    logic [ANGLE_FRAC_BITS:0] r_q;
    logic [hnta_pkg::ANGLE_BITS-1:0] r_ang;
    logic                  r_ovalid;
    logic [hnta_pkg::ANGLE_BITS-1:0] r_o_angle;
    logic [hnta_pkg::INDEX_BITS-1:0] r_o_near;

    logic [IDX_W-1:0]      w_last;
    logic [IDX_W-1:0]      w_next;
    logic [PROD_W:0]       w_sum;
    logic                  w_big;
    logic                  w_accept;
    logic [6:0]            w_widx;
    logic [6:0]            w_ph7;
    logic                  w_sq_done;
    logic [ROOT_W-1:0]     w_root;
    logic                  w_div_done;
    logic [ANGLE_FRAC_BITS:0] w_quot;
    logic signed [ANG_W-1:0] w_base;
    logic signed [ANG_W-1:0] w_a0;
    logic signed [ANG_W-1:0] w_a1;
    logic signed [ANG_W-1:0] w_a2;

    assign s_tready = (r_state == S_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_widx   = 7'(s_tdata[3:0]);
    assign w_ph7    = 7'(r_phase);
    assign w_last   = (r_phase == '0) ? IDX_W'(NUM_ENTRIES-1) : r_phase - 1'b1;
    assign w_next   = (r_phase == IDX_W'(NUM_ENTRIES-1)) ? '0 : r_phase + 1'b1;
    assign w_sum    = (PROD_W+1)'(r_nn) + (PROD_W+1)'(r_ll);
    assign w_big    = (w_sum[PROD_W:SB] != '0);

    // calibration table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_tab[i][k] <=
                        hnta_pkg::DEFAULT_TRIPLES[i % hnta_pkg::DEFAULT_ROWS][k]
                            [SAMPLE_BITS-1:0];
                end
            end
        end else if (w_accept && s_tuser[0] == hnta_pkg::OP_WRITE
                     && w_widx < 7'(NUM_ENTRIES)) begin
            r_tab[w_widx[IDX_W-1:0]] <= {to_smp(s_tdata[39:28]),
                                         to_smp(s_tdata[27:16]),
                                         to_smp(s_tdata[15:4])};
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_lane
        hnta_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_entry (r_tab[g]),
            .i_ref   (r_ref),
            .o_d2    (w_lane[g])
        );
    end

    hnta_sqrt #(.IN_W(D2_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ROOT),
        .i_d2    (r_d2[r_k]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    hnta_div #(.FRAC(ANGLE_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV),
        .i_mag   (r_neg ? SB'(r_ll - r_nn) : SB'(r_nn - r_ll)),
        .i_den   (SB'(w_sum)),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_base = ANG_W'(r_phase) <<< (ANGLE_FRAC_BITS + 1);
        w_a0   = r_neg ? w_base + ANG_W'(r_q) : w_base - ANG_W'(r_q);
        w_a1   = (w_a0 < 0) ? w_a0 + TURN : w_a0;
        w_a2   = (w_a1 > TURN) ? w_a1 - TURN : w_a1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            if (r_ovalid && m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && s_tuser[0] == hnta_pkg::OP_CONVERT) begin
                        r_ref   <= {to_smp(s_tdata[39:28]), to_smp(s_tdata[27:16]),
                                    to_smp(s_tdata[15:4])};
                        r_k     <= '0;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_cnt   <= '0;
                    r_state <= (r_k == 2'd0) ? S_SCAN : S_GET;
                end
                S_SCAN: begin
                    if (r_cnt == '0 || w_lane[r_cnt] < r_best) begin
                        r_best  <= w_lane[r_cnt];
                        r_phase <= r_cnt;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IDX_W'(NUM_ENTRIES-1)) begin
                        r_state <= S_GET;
                    end
                end
                S_GET: begin
                    r_d2[r_k] <= w_lane[r_k[0] ? w_next : w_last];
                    r_k       <= r_k + 1'b1;
                    if (r_k == 2'd1) begin
                        r_ref   <= r_tab[r_phase];
                        r_state <= S_DIST;
                    end else if (r_k == 2'd3) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (w_sq_done) begin
                        r_rt[r_k] <= w_root;
                        r_k       <= r_k + 1'b1;
                        r_state   <= (r_k == 2'd3) ? S_MULN : S_ROOT;
                    end
                end
                S_MULN: begin
                    r_nn    <= r_rt[1] * r_rt[2];
                    r_state <= S_MULL;
                end
                S_MULL: begin
                    r_ll    <= r_rt[0] * r_rt[3];
                    r_zero  <= (r_rt[2] == '0) || (r_rt[3] == '0);
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (w_big) begin
                        r_nn <= r_nn >> 1;
                        r_ll <= r_ll >> 1;
                    end else if (r_zero || w_sum == '0) begin
                        r_q     <= '0;
                        r_neg   <= 1'b0;
                        r_state <= S_ANG;
                    end else begin
                        r_neg   <= (r_ll > r_nn);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_q     <= w_quot;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_ang   <= hnta_pkg::ANGLE_BITS'(w_a2);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_o_angle <= r_ang;
                        r_o_near  <= w_ph7[hnta_pkg::INDEX_BITS-1:0];
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {5'b0, r_o_near, r_o_angle};

    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_tuser[0] == hnta_pkg::OP_CONVERT) |=> !s_tready)
        else $error("convert beat did not hold off input");

    a_den_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !w_big)
        else $error("divisor above scale limit");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (w_ph7 < 7'(NUM_ENTRIES)))
        else $error("nearest entry out of table");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for hall_nearest_table_angle, calibration writes
// and angle conversions on random stream handshakes, checked by a local predictor;
// depends on hnta_pkg and the rtl/core sources
`default_nettype none
module tb_top;

    localparam int N_ENT   = hnta_pkg::NUM_ENTRIES_DEF;
    localparam int FRAC    = hnta_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int N_RAND  = 1180;
    localparam int N_DIR   = 14;

    typedef struct packed {
        logic [11:0] c;
        logic [11:0] b;
        logic [11:0] a;
    } triple_t;

    typedef struct packed {
        logic [14:0] angle;
        logic [3:0]  entry;
    } angle_res_t;

    typedef struct {
        logic       op;
        logic [3:0] idx;
        triple_t    smp;
        bit         typed;
        angle_res_t res;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // entry_index[3:0], a[15:4], b[27:16], c[39:28]
    logic [0:0]  s_tuser;   // operation[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // angle[14:0], nearest_entry[18:15], zero[23:19]

    hall_nearest_table_angle dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    triple_t    cal_table [N_ENT];
    angle_res_t angle_q [$];
    int         err_cnt;
    int         beats_in;
    int         n_conv;
    int         n_write;
    int         n_flat;
    bit         quiet;
    bit         sending_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned dist_sq(triple_t p, triple_t q);
        longint signed da;
        longint signed db;
        longint signed dc;
        da = longint'(p.a) - longint'(q.a);
        db = longint'(p.b) - longint'(q.b);
        dc = longint'(p.c) - longint'(q.c);
        return da * da + db * db + dc * dc;
    endfunction

    function automatic longint unsigned root_q14(longint unsigned d2);
        return int_sqrt(d2 << hnta_pkg::ROOT_SHIFT);
    endfunction

    function automatic angle_res_t predict_angle(triple_t smp);
        longint unsigned dsq [N_ENT];
        longint unsigned sn, sl, dn, dl, nn, ll, den, mag, q;
        longint signed   corr, ang, turn;
        int              ph, lst, nxt;
        angle_res_t      r;
        ph = 0;
        corr = 0;
        for (int i = 0; i < N_ENT; i++) begin
            dsq[i] = dist_sq(cal_table[i], smp);
            if (dsq[i] < dsq[ph]) ph = i;
        end
        lst = (ph == 0) ? N_ENT - 1 : ph - 1;
        nxt = (ph == N_ENT - 1) ? 0 : ph + 1;
        sl = root_q14(dsq[lst]);
        sn = root_q14(dsq[nxt]);
        dl = root_q14(dist_sq(cal_table[ph], cal_table[lst]));
        dn = root_q14(dist_sq(cal_table[nxt], cal_table[ph]));
        if (dl != 0 && dn != 0) begin
            nn = sn * dl;
            ll = sl * dn;
            while (nn + ll >= (64'd1 << hnta_pkg::SCALE_BITS)) begin
                nn >>= 1;
                ll >>= 1;
            end
            den = nn + ll;
            if (den != 0) begin
                mag = (nn >= ll) ? nn - ll : ll - nn;
                q = ((mag << FRAC) + (den >> 1)) / den;
                corr = (nn >= ll) ? longint'(q) : -longint'(q);
            end
        end
        if (corr == 0) n_flat++;
        turn = longint'(2 * N_ENT) << FRAC;
        ang = (longint'(2 * ph) << FRAC) - corr;
        if (ang < 0) ang += turn;
        if (ang > turn) ang -= turn;
        r.angle = ang[14:0];
        r.entry = ph[3:0];
        return r;
    endfunction

    // apply one accepted beat: a write updates the local table, a convert queues its result
    task automatic accept_beat(stim_row_t row);
        angle_res_t r;
        beats_in++;
        if (row.op == hnta_pkg::OP_WRITE) begin
            n_write++;
            if (row.idx < N_ENT) cal_table[row.idx] = row.smp;
        end else begin
            n_conv++;
            r = predict_angle(row.smp);
            if (row.typed && r != row.res) begin
                report_mismatch("directed angle", r.angle, row.res.angle);
            end
            angle_q.push_back(row.typed ? row.res : r);
        end
    endtask

    task automatic send_beat(stim_row_t row);
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {row.smp.c, row.smp.b, row.smp.a, row.idx};
        do @(posedge i_clk); while (!s_tready);
        accept_beat(row);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic triple_t default_triple(int i);
        triple_t t;
        t.a = hnta_pkg::DEFAULT_TRIPLES[i % hnta_pkg::DEFAULT_ROWS][0][11:0];
        t.b = hnta_pkg::DEFAULT_TRIPLES[i % hnta_pkg::DEFAULT_ROWS][1][11:0];
        t.c = hnta_pkg::DEFAULT_TRIPLES[i % hnta_pkg::DEFAULT_ROWS][2][11:0];
        return t;
    endfunction

    function automatic logic [11:0] jitter(logic [11:0] v, int span);
        int x;
        x = int'(v) + $urandom_range(0, 2 * span) - span;
        if (x < 0) x = 0;
        if (x > 4095) x = 4095;
        return x[11:0];
    endfunction

    function automatic triple_t rand_triple();
        triple_t t;
        t.a = $urandom_range(0, 4095);
        t.b = $urandom_range(0, 4095);
        t.c = $urandom_range(0, 4095);
        return t;
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t row;
        int        k;
        int        sel;
        int        span;
        row.typed = 1'b0;
        row.res   = '0;
        row.idx   = $urandom_range(0, 15);
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            // sample near a table entry
            k = $urandom_range(0, N_ENT - 1);
            span = ($urandom_range(0, 3) == 0) ? 200 : 40;
            row.op = hnta_pkg::OP_CONVERT;
            row.smp.a = jitter(cal_table[k].a, span);
            row.smp.b = jitter(cal_table[k].b, span);
            row.smp.c = jitter(cal_table[k].c, span);
        end else if (sel < 86) begin
            row.op  = hnta_pkg::OP_CONVERT;
            row.smp = rand_triple();
        end else begin
            row.op = hnta_pkg::OP_WRITE;
            k = $urandom_range(0, 9);
            if (k < 5) begin
                row.smp = default_triple(row.idx);
            end else if (k < 7) begin
                // duplicate a neighbor to get a zero step length
                row.smp = cal_table[(row.idx + 1) % N_ENT];
            end else begin
                row.smp = rand_triple();
            end
        end
        return row;
    endfunction

    stim_row_t dir_tab [N_DIR];

    initial begin
        stim_row_t row;
        err_cnt = 0;
        beats_in = 0;
        n_conv = 0;
        n_write = 0;
        n_flat = 0;
        quiet = 1'b0;
        sending_done = 1'b0;
        for (int i = 0; i < N_ENT; i++) cal_table[i] = default_triple(i);

        //                op                    idx    sample (c,b,a)          typed  angle,entry
        dir_tab[0]  = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd2995, 12'd2902, 12'd2626}, 1'b0, '0};
        dir_tab[1]  = '{hnta_pkg::OP_CONVERT, 4'd15, {12'd0,    12'd0,    12'd0},    1'b0, '0};
        dir_tab[2]  = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd4095, 12'd4095, 12'd4095}, 1'b0, '0};
        dir_tab[3]  = '{hnta_pkg::OP_CONVERT, 4'd10, {12'd4095, 12'd0,    12'd4095}, 1'b0, '0};
        dir_tab[4]  = '{hnta_pkg::OP_WRITE,   4'd5,  {12'd2549, 12'd2224, 12'd2263}, 1'b0, '0};
        // entries 4 and 5 equal: lowest index wins, zero step gives no correction
        dir_tab[5]  = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd2549, 12'd2224, 12'd2263}, 1'b1,
                        '{15'd8192, 4'd4}};
        dir_tab[6]  = '{hnta_pkg::OP_WRITE,   4'd15, {12'd0,    12'd0,    12'd0},    1'b0, '0};
        dir_tab[7]  = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd2549, 12'd2224, 12'd2263}, 1'b1,
                        '{15'd8192, 4'd4}};
        dir_tab[8]  = '{hnta_pkg::OP_WRITE,   4'd0,  {12'd0,    12'd0,    12'd0},    1'b0, '0};
        dir_tab[9]  = '{hnta_pkg::OP_WRITE,   4'd11, {12'd4095, 12'd4095, 12'd4095}, 1'b0, '0};
        dir_tab[10] = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd0,    12'd0,    12'd0},    1'b0, '0};
        dir_tab[11] = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd4095, 12'd4095, 12'd4095}, 1'b0, '0};
        dir_tab[12] = '{hnta_pkg::OP_WRITE,   4'd12, {12'd4095, 12'd4095, 12'd4095}, 1'b0, '0};
        dir_tab[13] = '{hnta_pkg::OP_CONVERT, 4'd0,  {12'd2426, 12'd2259, 12'd2418}, 1'b0, '0};

        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            send_beat(dir_tab[i]);
            sender_gap();
        end
        for (int i = 0; i < N_RAND; i++) begin
            if (i > N_RAND - 150) quiet = 1'b1;
            row = rand_row();
            send_beat(row);
            sender_gap();
        end
        s_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // output side: checks and random backpressure, one long hold-off
    initial begin
        angle_res_t got;
        angle_res_t want;
        int         hold;
        bit         long_done;
        hold = 0;
        long_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got.angle = m_tdata[14:0];
                got.entry = m_tdata[18:15];
                if (angle_q.size() == 0) begin
                    report_mismatch("unexpected beat, angle", got.angle, -1);
                end else begin
                    want = angle_q.pop_front();
                    if (got.angle != want.angle)
                        report_mismatch("angle", got.angle, want.angle);
                    if (got.entry != want.entry)
                        report_mismatch("nearest_entry", got.entry, want.entry);
                    if (m_tdata[23:19] != '0)
                        report_mismatch("pad bits", m_tdata[23:19], 0);
                end
            end
            if (!long_done && beats_in >= 400) begin
                long_done = 1'b1;
                hold = 400;
            end else if (hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 6);
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (sending_done);
        wait (angle_q.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("covered %0d conversions and %0d table writes", n_conv, n_write);
        $display("%0d conversions took the zero-correction path", n_flat);
        if (err_cnt == 0 && angle_q.size() == 0) begin
            $display("[hall_nearest_table_angle] OK");
        end else begin
            $display("[hall_nearest_table_angle] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("[hall_nearest_table_angle] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/hnta_pkg.sv
rtl/core/hnta_lane.sv
rtl/core/hnta_sqrt.sv
rtl/core/hnta_div.sv
rtl/core/hall_nearest_table_angle.sv
sim/tb_top.sv
